>>> hw/rtl/gmm_pkg.sv
// ----------------------------------------------------------------------------
// gmm_pkg
// shared constants for the per-group maximum mask block
// ----------------------------------------------------------------------------
package gmm_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int GROUPS     = 16;
    localparam int SCORE_BITS = 16;

    localparam int GROUP_W = $clog2(GROUPS);
    localparam int IDX_W   = $clog2(MAX_ITEMS);
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int ITEM_W  = SCORE_BITS + GROUP_W;

    // port field widths
    localparam int SCORE_IN_W  = 16;
    localparam int GROUP_IN_W  = 4;
    localparam int POS_W       = 6;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 8;

endpackage

>>> hw/rtl/gmm_ram.sv
// ----------------------------------------------------------------------------
// gmm_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/group_max_mask_top.sv
// ----------------------------------------------------------------------------
// group_max_mask_top
// buffers one set of scored items, keeps a running maximum per group and
// replays the set with a flag on every item that matches its group maximum
// ----------------------------------------------------------------------------
// load: accept a transfer, then the group table read-modify-write; no new transfer meanwhile
// replay: after the set_end transfer, the table update, item read, group table read and
//   compare states precede the first result; each later result repeats the item read
//   feeding the group table read and the compare, which waits while the output is stalled
// reset: control, count, overflow and seen bits clear; rams are not cleared
// ----------------------------------------------------------------------------
module group_max_mask_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gmm_pkg::S_TDATA_W-1:0]  s_tdata,  // score[15:0], group[19:16], zero
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gmm_pkg::M_TDATA_W-1:0]  m_tdata,  // selected[0], position[6:1], zero
    output logic                           m_tlast,
    output logic                           m_tuser   // overflowed
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_RITEM,
        ST_RGRP,
        ST_RCMP
    } state_t;

    state_t                          state_reg, state_next;
    logic [gmm_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                            ovf_reg, ovf_next;
    logic [gmm_pkg::GROUPS-1:0]      seen_reg, seen_next;
    logic [gmm_pkg::IDX_W-1:0]       kidx_reg, kidx_next;
    logic                            kept_reg, kept_next;
    logic                            last_reg, last_next;
    logic [gmm_pkg::SCORE_BITS-1:0]  score_reg, score_next;
    logic [gmm_pkg::GROUP_W-1:0]     grp_reg, grp_next;
    logic                            mvalid_reg, mvalid_next;
    logic                            sel_reg, sel_next;
    logic [gmm_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                            fin_reg, fin_next;
    logic                            movf_reg, movf_next;

    logic                            in_xfer;
    logic [gmm_pkg::SCORE_BITS-1:0]  in_score;
    logic [gmm_pkg::GROUP_W-1:0]     in_grp;
    logic                            has_room;
    logic                            out_free;
    logic                            is_final;

    logic                            item_we, item_re;
    logic [gmm_pkg::IDX_W-1:0]       item_waddr, item_raddr;
    logic [gmm_pkg::ITEM_W-1:0]      item_wdata, item_rdata;
    logic                            gmax_we, gmax_re;
    logic [gmm_pkg::GROUP_W-1:0]     gmax_waddr, gmax_raddr;
    logic [gmm_pkg::SCORE_BITS-1:0]  gmax_wdata, gmax_rdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign in_score = s_tdata[gmm_pkg::SCORE_BITS-1:0];
    assign in_grp   = s_tdata[gmm_pkg::SCORE_IN_W +: gmm_pkg::GROUP_W];
    assign has_room = (count_reg < gmm_pkg::CNT_W'(gmm_pkg::MAX_ITEMS));
    assign out_free = !mvalid_reg || m_tready;
    assign is_final = ((gmm_pkg::CNT_W'(kidx_reg) + gmm_pkg::CNT_W'(1)) == count_reg);

    // item buffer
    assign item_we    = in_xfer && has_room;
    assign item_waddr = count_reg[gmm_pkg::IDX_W-1:0];
    assign item_wdata = {in_grp, in_score};
    assign item_re    = (state_reg == ST_RITEM);
    assign item_raddr = kidx_reg;

    // group maximum table
    assign gmax_re    = in_xfer || (state_reg == ST_RGRP);
    assign gmax_raddr = (state_reg == ST_RGRP) ?
                        item_rdata[gmm_pkg::SCORE_BITS +: gmm_pkg::GROUP_W] : in_grp;
    assign gmax_we    = (state_reg == ST_UPD) && kept_reg &&
                        (!seen_reg[grp_reg] || ($signed(score_reg) > $signed(gmax_rdata)));
    assign gmax_waddr = grp_reg;
    assign gmax_wdata = score_reg;

    gmm_ram #(
        .WIDTH (gmm_pkg::ITEM_W),
        .DEPTH (gmm_pkg::MAX_ITEMS)
    ) u_item_ram (
        .clk     (clk),
        .wr_en   (item_we),
        .wr_addr (item_waddr),
        .wr_data (item_wdata),
        .rd_en   (item_re),
        .rd_addr (item_raddr),
        .rd_data (item_rdata)
    );

    gmm_ram #(
        .WIDTH (gmm_pkg::SCORE_BITS),
        .DEPTH (gmm_pkg::GROUPS)
    ) u_gmax_ram (
        .clk     (clk),
        .wr_en   (gmax_we),
        .wr_addr (gmax_waddr),
        .wr_data (gmax_wdata),
        .rd_en   (gmax_re),
        .rd_addr (gmax_raddr),
        .rd_data (gmax_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        seen_next   = seen_reg;
        kidx_next   = kidx_reg;
        kept_next   = kept_reg;
        last_next   = last_reg;
        score_next  = score_reg;
        grp_next    = grp_reg;
        mvalid_next = mvalid_reg && !m_tready;
        sel_next    = sel_reg;
        pos_next    = pos_reg;
        fin_next    = fin_reg;
        movf_next   = movf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    score_next = in_score;
                    grp_next   = in_grp;
                    last_next  = s_tlast;
                    kept_next  = has_room;
                    if (has_room)
                    begin
                        count_next = count_reg + gmm_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (kept_reg)
                begin
                    seen_next[grp_reg] = 1'b1;
                end
                kidx_next  = '0;
                state_next = last_reg ? ST_RITEM : ST_IDLE;
            end
            ST_RITEM:
            begin
                state_next = ST_RGRP;
            end
            ST_RGRP:
            begin
                score_next = item_rdata[gmm_pkg::SCORE_BITS-1:0];
                grp_next   = item_rdata[gmm_pkg::SCORE_BITS +: gmm_pkg::GROUP_W];
                state_next = ST_RCMP;
            end
            ST_RCMP:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    sel_next    = seen_reg[grp_reg] && (gmax_rdata == score_reg);
                    pos_next    = gmm_pkg::POS_W'(kidx_reg);
                    fin_next    = is_final;
                    movf_next   = ovf_reg;
                    if (is_final)
                    begin
                        seen_next  = '0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        kidx_next  = kidx_reg + gmm_pkg::IDX_W'(1);
                        state_next = ST_RITEM;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            seen_reg   <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            seen_reg   <= seen_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        kidx_reg  <= kidx_next;
        kept_reg  <= kept_next;
        last_reg  <= last_next;
        score_reg <= score_next;
        grp_reg   <= grp_next;
        sel_reg   <= sel_next;
        pos_reg   <= pos_next;
        fin_reg   <= fin_next;
        movf_reg  <= movf_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(gmm_pkg::M_TDATA_W - gmm_pkg::POS_W - 1){1'b0}}, pos_reg, sel_reg};
    assign m_tlast  = fin_reg;
    assign m_tuser  = movf_reg;

endmodule

>>> hw/rtl/gmm_checker.sv
// ----------------------------------------------------------------------------
// gmm_checker
// port-level checks on the per-group maximum mask block, bound to the top
// ----------------------------------------------------------------------------
module gmm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [gmm_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           m_tlast,
    input  logic                           m_tuser
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    else $error("result payload changed while stalled");

    // each input transfer is followed by a table update cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input taken during table update");

    // the end of a set starts the replay, no input taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> ##1 !s_tready)
    else $error("input taken at start of replay");

endmodule

bind group_max_mask_top gmm_checker u_gmm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

>>> sim/tb_group_max_mask_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_group_max_mask_top
// self-checking bench for the per-group maximum mask block: a short table of
// directed sets, a hold-off on the output side that fills the block, then
// random sets under three idling mixes, every result compared in order with
// a behavioural copy of the group maximum tracking
// ----------------------------------------------------------------------------
module tb_group_max_mask_top;

    localparam int HALF_PERIOD  = 6;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 90;

    typedef struct packed {
        logic                          selected;
        logic [gmm_pkg::POS_W-1:0]     position;
        logic                          final_result;
        logic                          overflowed;
    } mark_t;

    typedef struct packed {
        logic signed [gmm_pkg::SCORE_IN_W-1:0] score;
        logic [gmm_pkg::GROUP_IN_W-1:0]        grp;
        logic                                  last;
        logic                                  typed;
        mark_t                                 mark;
    } dir_row_t;

    localparam mark_t SOLE_MARK = '{1'b1, 6'd0, 1'b1, 1'b0};
    localparam mark_t NO_MARK   = '0;

    localparam int DIR_ROWS = 21;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{16'sh7fff,  4'd15, 1'b1, 1'b1, SOLE_MARK},
        '{16'sh8000,  4'd0,  1'b1, 1'b1, SOLE_MARK},
        '{16'sh8000,  4'd0,  1'b0, 1'b0, NO_MARK},
        '{16'sh8000,  4'd0,  1'b0, 1'b0, NO_MARK},
        '{16'sd0,     4'd5,  1'b0, 1'b0, NO_MARK},
        '{-16'sd1,    4'd5,  1'b0, 1'b0, NO_MARK},
        '{16'sd1,     4'd5,  1'b0, 1'b0, NO_MARK},
        '{16'sh7fff,  4'd15, 1'b0, 1'b0, NO_MARK},
        '{16'sh7fff,  4'd15, 1'b0, 1'b0, NO_MARK},
        '{16'sh7fff,  4'd0,  1'b0, 1'b0, NO_MARK},
        '{-16'sd32767, 4'd10, 1'b0, 1'b0, NO_MARK},
        '{16'sh8000,  4'd10, 1'b0, 1'b0, NO_MARK},
        '{16'sd100,   4'd3,  1'b0, 1'b0, NO_MARK},
        '{16'sd100,   4'd3,  1'b1, 1'b0, NO_MARK},
        '{16'sd0,     4'd7,  1'b1, 1'b1, SOLE_MARK},
        '{-16'sd5,    4'd12, 1'b0, 1'b0, NO_MARK},
        '{-16'sd5,    4'd12, 1'b0, 1'b0, NO_MARK},
        '{-16'sd5,    4'd12, 1'b0, 1'b0, NO_MARK},
        '{-16'sd6,    4'd12, 1'b0, 1'b0, NO_MARK},
        '{-16'sd4,    4'd12, 1'b1, 1'b0, NO_MARK},
        '{-16'sd1,    4'd15, 1'b1, 1'b1, SOLE_MARK}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [gmm_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [gmm_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tlast;
    logic                           m_tuser;

    // behavioural copy of the set buffer and group tables
    logic signed [gmm_pkg::SCORE_IN_W-1:0] held_score [gmm_pkg::MAX_ITEMS];
    logic [gmm_pkg::GROUP_IN_W-1:0]        held_group [gmm_pkg::MAX_ITEMS];
    logic signed [gmm_pkg::SCORE_IN_W-1:0] group_peak [gmm_pkg::GROUPS];
    logic                                  group_hit  [gmm_pkg::GROUPS];
    int unsigned                           held_count;
    logic                                  set_dropped;

    mark_t pending_marks [$];

    int errors;
    int items_sent;
    int src_idle_pct;
    int sink_idle_pct;
    int sink_hold_req;
    int sink_hold_left;
    int quiet_cycles;

    group_max_mask_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    // running maximum per group, marks queued when the set closes
    task automatic track_group_peaks(input logic signed [gmm_pkg::SCORE_IN_W-1:0] score,
                                     input logic [gmm_pkg::GROUP_IN_W-1:0] grp,
                                     input logic last);
        mark_t m;
        if (held_count < gmm_pkg::MAX_ITEMS)
        begin
            held_score[held_count] = score;
            held_group[held_count] = grp;
            if (!group_hit[grp] || score > group_peak[grp])
            begin
                group_peak[grp] = score;
                group_hit[grp]  = 1'b1;
            end
            held_count++;
        end
        else
            set_dropped = 1'b1;
        if (last)
        begin
            for (int k = 0; k < held_count; k++)
            begin
                m.selected     = group_hit[held_group[k]] &&
                                 held_score[k] == group_peak[held_group[k]];
                m.position     = k[gmm_pkg::POS_W-1:0];
                m.final_result = (k + 1 == held_count);
                m.overflowed   = set_dropped;
                pending_marks  = {pending_marks, m};
            end
            for (int g = 0; g < gmm_pkg::GROUPS; g++)
                group_hit[g] = 1'b0;
            held_count  = 0;
            set_dropped = 1'b0;
        end
    endtask

    task automatic send_item(input logic signed [gmm_pkg::SCORE_IN_W-1:0] score,
                             input logic [gmm_pkg::GROUP_IN_W-1:0] grp, input logic last,
                             input logic typed = 1'b0, input mark_t typed_mark = '0);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(gmm_pkg::S_TDATA_W - gmm_pkg::SCORE_IN_W - gmm_pkg::GROUP_IN_W){1'b0}},
                     grp, score};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_group_peaks(score, grp, last);
        if (typed)
        begin
            pending_marks[pending_marks.size() - 1] = typed_mark;
        end
        items_sent++;
    endtask

    task automatic send_set(input int n);
        int gtop;
        logic signed [gmm_pkg::SCORE_IN_W-1:0] sc;
        logic [gmm_pkg::GROUP_IN_W-1:0] g;
        gtop = ($urandom_range(3) == 0) ? 15 : int'($urandom_range(15));
        for (int i = 0; i < n; i++)
        begin
            g = gmm_pkg::GROUP_IN_W'($urandom_range(gtop));
            case ($urandom_range(3))
                0: sc = gmm_pkg::SCORE_IN_W'($urandom);
                1: sc = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                default:
                begin
                    sc = gmm_pkg::SCORE_IN_W'($urandom_range(4));
                    sc = sc - 16'sd2;
                end
            endcase
            send_item(sc, g, i == n - 1);
        end
    endtask

    task automatic send_random_set();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            send_set($urandom_range(12, 1));
        else if (r < 93)
            send_set($urandom_range(40, 13));
        else
            send_set($urandom_range(70, 60));
    endtask

    task automatic wait_marks_drained();
        wait (pending_marks.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct);
        int start;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
            send_random_set();
    endtask

    // output side: check every transfer, then pick the next ready level
    initial
    begin
        mark_t want;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_marks.size() == 0)
                begin
                    $display("%0t unexpected result: selected %0d position %0d last %0d ovf %0d",
                             $time, m_tdata[0], m_tdata[6:1], m_tlast, m_tuser);
                    errors++;
                end
                else
                begin
                    want = pending_marks.pop_front();
                    if (m_tdata[0] !== want.selected)
                    begin
                        $display("%0t selected mismatch: expected %0d actual %0d",
                                 $time, want.selected, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[6:1] !== want.position)
                    begin
                        $display("%0t position mismatch: expected %0d actual %0d",
                                 $time, want.position, m_tdata[6:1]);
                        errors++;
                    end
                    if (m_tlast !== want.final_result)
                    begin
                        $display("%0t final_result mismatch: expected %0d actual %0d",
                                 $time, want.final_result, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== want.overflowed)
                    begin
                        $display("%0t overflowed mismatch: expected %0d actual %0d",
                                 $time, want.overflowed, m_tuser);
                        errors++;
                    end
                end
            end
            if (sink_hold_req > 0)
            begin
                sink_hold_left = sink_hold_req;
                sink_hold_req  = 0;
            end
            if (sink_hold_left > 0)
            begin
                sink_hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        errors         = 0;
        items_sent     = 0;
        src_idle_pct   = 0;
        sink_idle_pct  = 0;
        sink_hold_req  = 0;
        sink_hold_left = 0;
        quiet_cycles   = 0;
        held_count     = 0;
        set_dropped    = 1'b0;
        for (int g = 0; g < gmm_pkg::GROUPS; g++)
            group_hit[g] = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets
        src_idle_pct  = 29;
        sink_idle_pct = 63;
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIR_TABLE[i].score, DIR_TABLE[i].grp, DIR_TABLE[i].last,
                      DIR_TABLE[i].typed, DIR_TABLE[i].mark);
        s_tvalid <= 1'b0;
        wait_marks_drained();

        // output held off while a full set with a dropped closing transfer
        // and then an exactly full set are offered
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        sink_hold_req = HOLD_CYCLES;
        send_set(gmm_pkg::MAX_ITEMS + 1);
        send_set(gmm_pkg::MAX_ITEMS);
        s_tvalid <= 1'b0;
        wait_marks_drained();

        run_phase(29, 63);
        run_phase(63, 29);
        run_phase(0, 0);
        s_tvalid <= 1'b0;
        wait_marks_drained();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
